// ===== rtl/pgm_pkg.sv =====
`timescale 1ns / 1ps
// package for the path rule glob matcher
// holds widths, request and mode codes, character constants, and fold and separator helpers
package pgm_pkg;

    localparam int MaxChars = 256;
    localparam int AddrW = $clog2(MaxChars);
    localparam int CntW = AddrW + 1;
    localparam int CharW = 16;
    localparam int QueueDepth = 4;
    localparam int QueueAw = $clog2(QueueDepth);

    typedef enum logic [1:0] {
        REQ_RULE_CHAR = 2'd0,
        REQ_PATH_CHAR = 2'd1,
        REQ_RULE_END  = 2'd2,
        REQ_PATH_END  = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        MODE_EXACT = 2'd0,
        MODE_DIR   = 2'd1,
        MODE_GLOB  = 2'd2,
        MODE_NEVER = 2'd3
    } t_mode;

    localparam logic [1:0] REG_MATCH_MODE = 2'd0;
    localparam logic [1:0] REG_RECURSIVE  = 2'd1;

    localparam logic [CharW-1:0] CH_STAR   = 16'h002A;
    localparam logic [CharW-1:0] CH_QUES   = 16'h003F;
    localparam logic [CharW-1:0] CH_BSLASH = 16'h005C;
    localparam logic [CharW-1:0] CH_SLASH  = 16'h002F;

    typedef struct packed {
        t_req             req;
        logic [CharW-1:0] ch;
    } t_item;

    function automatic logic [CharW-1:0] fold(input logic [CharW-1:0] c);
        if (c >= 16'h0061 && c <= 16'h007A) begin
            return c - 16'h0020;
        end
        return c;
    endfunction

    function automatic logic is_sep(input logic [CharW-1:0] c);
        return (c == CH_BSLASH) || (c == CH_SLASH);
    endfunction

endpackage

// ===== rtl/path_rule_glob_matcher.sv =====
`timescale 1ns / 1ps
// Path rule matcher: items pass a four-entry queue; character and end-of-rule
// items are stored while the engine is idle, and an end-of-path item runs a
// match sequencer that reads both character memories, each compare, backtrack
// or star step going through ISSUE, WAIT and EVAL or STAR (registered memory
// read), so match time grows with rule and path length and with glob
// backtracking. The result waits in an output register. Depends on pgm_pkg, pgm_queue, pgm_engine
module path_rule_glob_matcher (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // req_type[1:0], char_code[17:2], zero pad
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // matched[0], overflow[1], zero pad
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [1:0]  i_cfg_data
);
    import pgm_pkg::*;

    t_mode r_mode;
    logic  r_recursive;
    t_item in_item, q_item;
    logic  q_full, q_empty, q_pop, push;
    logic  matched, overflow, busy;

    assign in_item.req = t_req'(s_axis_tdata[1:0]);
    assign in_item.ch  = s_axis_tdata[17:2];
    assign s_axis_tready = !q_full;
    assign push = s_axis_tvalid && !q_full;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_EXACT;
            r_recursive <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_MATCH_MODE: r_mode      <= t_mode'(i_cfg_data);
                REG_RECURSIVE:  r_recursive <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    pgm_queue u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_item (in_item),
        .o_full (q_full),
        .i_pop  (q_pop),
        .o_empty(q_empty),
        .o_item (q_item)
    );

    pgm_engine u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_item     (q_item),
        .o_pop      (q_pop),
        .i_mode     (r_mode),
        .i_recursive(r_recursive),
        .o_res_valid(m_axis_tvalid),
        .i_res_ready(m_axis_tready),
        .o_matched  (matched),
        .o_overflow (overflow),
        .o_busy     (busy)
    );

    assign m_axis_tdata = {6'b0, overflow, matched};

    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && overflow |-> !matched)
        else $error("match reported with overflow");
    a_no_pop_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !q_pop)
        else $error("queue popped while result pending");
    a_res_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> busy)
        else $error("result shown while engine idle");
endmodule

// ===== rtl/pgm_ram.sv =====
`timescale 1ns / 1ps
// generic single-port-write ram with one registered read port
// no dependencies
module pgm_ram #(
    parameter int Width = 16,
    parameter int Depth = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/pgm_queue.sv =====
`timescale 1ns / 1ps
// short fifo of input items between the front and the back engine
// depends on pgm_pkg
module pgm_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  pgm_pkg::t_item i_item,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output pgm_pkg::t_item o_item
);
    import pgm_pkg::*;

    t_item              r_buf [QueueDepth];
    logic [QueueAw-1:0] r_wp, r_rp;
    logic [QueueAw:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_full  = (r_cnt == (QueueAw+1)'(QueueDepth));
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_buf[r_rp];
endmodule

// ===== rtl/pgm_engine.sv =====
`timescale 1ns / 1ps
// back engine: stores rule and path characters and runs the match sequencer
// depends on pgm_pkg and pgm_ram
module pgm_engine (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_empty,
    input  pgm_pkg::t_item  i_item,
    output logic            o_pop,
    input  pgm_pkg::t_mode  i_mode,
    input  logic            i_recursive,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output logic            o_matched,
    output logic            o_overflow,
    output logic            o_busy
);
    import pgm_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_ISSUE = 7'b0000010,
        ST_WAIT  = 7'b0000100,
        ST_EVAL  = 7'b0001000,
        ST_STAR  = 7'b0010000,
        ST_DONE  = 7'b0100000,
        ST_OUT   = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [CntW-1:0] r_rcnt, r_pcnt;
    logic            r_rclosed, r_rovf, r_povf;

    // match cursors and bookmarks
    logic [CntW-1:0] r_pi, r_si, r_sp, r_ss, r_dp, r_ds;
    logic            r_sv, r_dv;
    logic            r_res, r_ovf;
    // second star of a run seen
    logic            r_star_seen;
    logic            r_pv;
    // walking a run of stars
    logic            r_in_star;

    logic [AddrW-1:0] rule_ra, path_ra;
    logic [CharW-1:0] rule_rd, path_rd;
    logic             rule_we, path_we;

    logic [CntW-1:0] n_pi, n_si, n_sp, n_ss, n_dp, n_ds;
    logic            n_sv, n_dv, n_res, n_star_seen, n_pv, n_in_star;

    assign rule_we = (r_state == ST_IDLE) && !i_empty && (i_item.req == REQ_RULE_CHAR)
                     && (r_rclosed || r_rcnt < CntW'(MaxChars));
    assign path_we = (r_state == ST_IDLE) && !i_empty && (i_item.req == REQ_PATH_CHAR)
                     && (r_pcnt < CntW'(MaxChars));

    pgm_ram #(.Width(CharW), .Depth(MaxChars)) u_rule_ram (
        .i_clk  (i_clk),
        .i_we   (rule_we),
        .i_waddr(r_rclosed ? '0 : r_rcnt[AddrW-1:0]),
        .i_wdata(i_item.ch),
        .i_raddr(rule_ra),
        .o_rdata(rule_rd)
    );

    pgm_ram #(.Width(CharW), .Depth(MaxChars)) u_path_ram (
        .i_clk  (i_clk),
        .i_we   (path_we),
        .i_waddr(r_pcnt[AddrW-1:0]),
        .i_wdata(i_item.ch),
        .i_raddr(path_ra),
        .o_rdata(path_rd)
    );

    always_comb begin
        // directory remainder scan and glob read path at r_si, rule at r_pi
        rule_ra = r_pi[AddrW-1:0];
        path_ra = r_si[AddrW-1:0];
        if (r_pv) begin
            // bookmark check reads path at ss
            path_ra = r_ss[AddrW-1:0];
        end
    end

    logic pi_in, si_in;
    assign pi_in = r_pi < r_rcnt;
    assign si_in = r_si < r_pcnt;

    always_comb begin
        n_state     = r_state;
        n_pi        = r_pi;
        n_si        = r_si;
        n_sp        = r_sp;
        n_ss        = r_ss;
        n_dp        = r_dp;
        n_ds        = r_ds;
        n_sv        = r_sv;
        n_dv        = r_dv;
        n_res       = r_res;
        n_star_seen = r_star_seen;
        n_pv        = r_pv;
        n_in_star   = r_in_star;
        o_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    if (i_item.req == REQ_PATH_END) begin
                        n_pi = '0;
                        n_si = '0;
                        n_sv = 1'b0;
                        n_dv = 1'b0;
                        n_pv = 1'b0;
                        n_in_star = 1'b0;
                        n_res = 1'b0;
                        if (r_rovf || r_povf || i_mode == MODE_NEVER) begin
                            n_state = ST_DONE;
                        end else if (i_mode == MODE_EXACT && r_rcnt != r_pcnt) begin
                            n_state = ST_DONE;
                        end else if (i_mode == MODE_DIR && r_pcnt <= r_rcnt) begin
                            n_state = ST_DONE;
                        end else begin
                            n_state = ST_ISSUE;
                        end
                    end
                end
            end
            ST_ISSUE: n_state = ST_WAIT;
            ST_WAIT:  n_state = r_in_star ? ST_STAR : ST_EVAL;
            ST_EVAL: begin
                n_state = ST_ISSUE;
                if (i_mode == MODE_GLOB) begin
                    if (r_pv) begin
                        // bookmark step, path_rd holds path[ss]
                        n_pv = 1'b0;
                        if (r_sv && r_ss < r_pcnt && !is_sep(path_rd)) begin
                            n_ss = r_ss + 1'b1;
                            n_pi = r_sp;
                            n_si = r_ss + 1'b1;
                        end else if (r_dv && r_ds < r_pcnt) begin
                            n_ds = r_ds + 1'b1;
                            n_pi = r_dp;
                            n_si = r_ds + 1'b1;
                            n_sv = 1'b0;
                        end else begin
                            n_res   = 1'b0;
                            n_state = ST_DONE;
                        end
                    end else if (!si_in && !pi_in) begin
                        n_res   = 1'b1;
                        n_state = ST_DONE;
                    end else if (pi_in && rule_rd == CH_STAR) begin
                        n_pi        = r_pi + 1'b1;
                        n_star_seen = 1'b0;
                        n_in_star   = 1'b1;
                    end else if (pi_in && si_in &&
                                 ((rule_rd == CH_QUES) ? !is_sep(path_rd)
                                                       : fold(rule_rd) == fold(path_rd))) begin
                        n_pi = r_pi + 1'b1;
                        n_si = r_si + 1'b1;
                    end else begin
                        n_pv = 1'b1;
                    end
                end else begin
                    // exact and directory: compare prefix, then directory remainder
                    if (r_si < r_rcnt) begin
                        if (fold(rule_rd) != fold(path_rd)) begin
                            n_res   = 1'b0;
                            n_state = ST_DONE;
                        end else begin
                            n_pi = r_pi + 1'b1;
                            n_si = r_si + 1'b1;
                        end
                    end else if (i_mode == MODE_EXACT || i_recursive || !si_in) begin
                        n_res   = 1'b1;
                        n_state = ST_DONE;
                    end else if (path_rd == CH_BSLASH) begin
                        n_res   = 1'b0;
                        n_state = ST_DONE;
                    end else begin
                        n_si = r_si + 1'b1;
                    end
                end
            end
            ST_STAR: begin
                // rule_rd holds rule[pi] past the stars walked so far
                if (pi_in && rule_rd == CH_STAR) begin
                    n_pi        = r_pi + 1'b1;
                    n_star_seen = 1'b1;
                    n_state     = ST_ISSUE;
                end else begin
                    n_in_star = 1'b0;
                    n_state   = ST_EVAL;
                    if (r_star_seen) begin
                        n_dv = 1'b1;
                        n_dp = r_pi;
                        n_ds = r_si;
                        n_sv = 1'b0;
                    end else begin
                        n_sv = 1'b1;
                        n_sp = r_pi;
                        n_ss = r_si;
                    end
                end
            end
            ST_DONE: n_state = ST_OUT;
            ST_OUT: begin
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_rcnt      <= '0;
            r_pcnt      <= '0;
            r_rclosed   <= 1'b1;
            r_rovf      <= 1'b0;
            r_povf      <= 1'b0;
            r_in_star   <= 1'b0;
            r_pv        <= 1'b0;
            r_star_seen <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_pv        <= n_pv;
            r_star_seen <= n_star_seen;
            r_in_star   <= n_in_star;
            if (r_state == ST_IDLE && !i_empty) begin
                unique case (i_item.req)
                    REQ_RULE_CHAR: begin
                        if (r_rclosed) begin
                            r_rclosed <= 1'b0;
                            r_rovf    <= 1'b0;
                            r_rcnt    <= CntW'(1);
                        end else if (r_rcnt < CntW'(MaxChars)) begin
                            r_rcnt <= r_rcnt + 1'b1;
                        end else begin
                            r_rovf <= 1'b1;
                        end
                    end
                    REQ_PATH_CHAR: begin
                        if (r_pcnt < CntW'(MaxChars)) begin
                            r_pcnt <= r_pcnt + 1'b1;
                        end else begin
                            r_povf <= 1'b1;
                        end
                    end
                    REQ_RULE_END: r_rclosed <= 1'b1;
                    REQ_PATH_END: r_ovf <= r_rovf || r_povf;
                    default: ;
                endcase
            end
            if (r_state == ST_OUT && i_res_ready) begin
                r_pcnt <= '0;
                r_povf <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_pi  <= n_pi;
        r_si  <= n_si;
        r_sp  <= n_sp;
        r_ss  <= n_ss;
        r_dp  <= n_dp;
        r_ds  <= n_ds;
        r_sv  <= n_sv;
        r_dv  <= n_dv;
        r_res <= n_res;
    end

    assign o_res_valid = (r_state == ST_OUT);
    assign o_matched   = r_res & ~r_ovf;
    assign o_overflow  = r_ovf;
    assign o_busy      = (r_state != ST_IDLE);
endmodule
